### sv/fsd_pkg.sv
// Package with types and constants shared by the sharer directory modules.
package fsd_pkg;
    localparam int ENTRIES_DEF = 128;
    localparam int SHARERS_DEF = 32;
    localparam int BITMAP_W    = 32;
    localparam int INODE_W     = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_RDRST  = 3'd3,
        REQ_DELETE = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BADID = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [INODE_W-1:0] fs_inode;
        logic [INODE_W-1:0] file_inode;
        logic [5:0]         sharer_id;
        logic               bad_id;
    } t_cmd;
endpackage

### sv/fsd_front.sv
// Front end: accepts request beats, flags invalid sharer ids and queues commands.
module fsd_front import fsd_pkg::*; #(
    parameter int SHARERS = SHARERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [INODE_W-1:0] i_fs_inode,
    input  logic [INODE_W-1:0] i_file_inode,
    input  logic [5:0] i_sharer_id,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);
    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.req_type   = i_req_type;
        w_cmd.fs_inode   = i_fs_inode;
        w_cmd.file_inode = i_file_inode;
        w_cmd.sharer_id  = i_sharer_id;
        w_cmd.bad_id     = ((i_req_type == REQ_ADD) || (i_req_type == REQ_REMOVE))
                           && ({1'b0, i_sharer_id} >= 7'(SHARERS));
    end

    assign o_ready     = (r_cnt != 2'(QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

### sv/fsd_back.sv
// Back end: scans the table one entry a cycle, updates it and holds the result.
module fsd_back import fsd_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic       o_hit,
    output logic [BITMAP_W-1:0] o_bitmap
);
    localparam int AW = $clog2(ENTRIES);

    logic [INODE_W-1:0]  r_fsi [ENTRIES];
    logic [INODE_W-1:0]  r_fi  [ENTRIES];
    logic [BITMAP_W-1:0] r_shr [ENTRIES];
    logic [ENTRIES-1:0]  r_vld;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [AW:0]   r_idx;
    logic [AW-1:0] r_slot, r_free;
    logic          r_found, r_has_free;
    logic [INODE_W-1:0]  r_rd_fsi, r_rd_fi;
    logic [BITMAP_W-1:0] r_rd_shr, r_slot_shr;
    logic          r_rd_ok;
    logic [AW-1:0] r_rd_addr;
    logic [1:0]    r_status;
    logic          r_hit;
    logic [BITMAP_W-1:0] r_bitmap;
    logic [BITMAP_W-1:0] w_bit;
    logic          w_match;

    assign w_bit   = (r_cmd.sharer_id < 6'(BITMAP_W))
                     ? (BITMAP_W'(1) << r_cmd.sharer_id[4:0]) : '0;
    assign w_match = r_rd_ok && r_vld[r_rd_addr] && (r_rd_fsi == r_cmd.fs_inode)
                     && (r_rd_fi == r_cmd.file_inode);

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_hit       = r_hit;
    assign o_bitmap    = r_bitmap;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd_valid) n_state = S_SCAN;
            S_SCAN:  if (r_found || (w_match && !r_found) ||
                         (!r_rd_ok && r_idx == (AW+1)'(ENTRIES))) n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_rd_fsi  <= r_fsi[r_idx[AW-1:0]];
        r_rd_fi   <= r_fi[r_idx[AW-1:0]];
        r_rd_shr  <= r_shr[r_idx[AW-1:0]];
        r_rd_addr <= r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                r_cmd      <= i_cmd;
                r_idx      <= '0;
                r_rd_ok    <= 1'b0;
                r_found    <= 1'b0;
                r_has_free <= 1'b0;
            end
            S_SCAN: begin
                r_rd_ok <= (r_idx != (AW+1)'(ENTRIES));
                if (r_idx != (AW+1)'(ENTRIES)) r_idx <= r_idx + (AW+1)'(1);
                if (w_match && !r_found) begin
                    r_found    <= 1'b1;
                    r_slot     <= r_rd_addr;
                    r_slot_shr <= r_rd_shr;
                end
                if (r_rd_ok && !r_vld[r_rd_addr] && !r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free     <= r_rd_addr;
                end
            end
            S_WRITE: begin
                r_hit    <= r_found;
                r_status <= ST_OK;
                r_bitmap <= '0;
                if (r_cmd.bad_id) begin
                    r_status <= ST_BADID;
                end else begin
                    case (r_cmd.req_type)
                        REQ_ADD: begin
                            if (r_found) begin
                                r_shr[r_slot] <= r_slot_shr | w_bit;
                            end else if (r_has_free) begin
                                r_fsi[r_free] <= r_cmd.fs_inode;
                                r_fi[r_free]  <= r_cmd.file_inode;
                                r_shr[r_free] <= w_bit;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        REQ_REMOVE: if (r_found) r_shr[r_slot] <= r_slot_shr & ~w_bit;
                        REQ_LOOKUP: if (r_found) r_bitmap <= r_slot_shr;
                        REQ_RDRST: if (r_found) begin
                            r_bitmap      <= r_slot_shr;
                            r_shr[r_slot] <= '0;
                        end
                        REQ_DELETE: if (r_found) r_bitmap <= r_slot_shr;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == S_WRITE && !r_cmd.bad_id) begin
            if (r_cmd.req_type == REQ_ADD && !r_found && r_has_free) r_vld[r_free] <= 1'b1;
            if (r_cmd.req_type == REQ_DELETE && r_found) r_vld[r_slot] <= 1'b0;
        end
    end
endmodule

### sv/file_sharer_directory.sv
// Top level of the sharer directory: front end, command queue and back end.
// Each request searches the table one entry per cycle through the single memory
// read port and stops at the first key match; a miss scans every entry. The
// result is then written back and held for the output handshake. The front end
// queues up to two requests while the back end is busy.
module file_sharer_directory import fsd_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int SHARERS = SHARERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // fs_inode, file_inode, sharer_id, zero pad
    input  logic [2:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // hit, sharer_bitmap, zero pad
    output logic [1:0]   m_axis_tuser   // status
);
    logic w_cmd_valid, w_cmd_ready, w_hit;
    t_cmd w_cmd;
    logic [BITMAP_W-1:0] w_bitmap;

    fsd_front #(.SHARERS(SHARERS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser),
        .i_fs_inode(s_axis_tdata[63:0]),
        .i_file_inode(s_axis_tdata[127:64]),
        .i_sharer_id(s_axis_tdata[133:128]),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    fsd_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(m_axis_tuser), .o_hit(w_hit), .o_bitmap(w_bitmap)
    );

    assign m_axis_tdata = {7'd0, w_bitmap, w_hit};
endmodule

### sv/fsd_checker.sv
// Port checker for the sharer directory and its bind to the top level.
module fsd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == 2'd2 |-> m_axis_tdata == 40'd0)
        else $error("table full result carries data");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
        else $error("miss returned a bitmap");
endmodule

bind file_sharer_directory fsd_checker u_fsd_checker (.*);
